/* rtl/core/nrc_pkg.sv */
// Shared constants, codes and types of the nonce replay cache.
package nrc_pkg;

   // Table geometry
   localparam int ENTRIES = 16384;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;

   // Field widths
   localparam int NONCE_W = 64;
   localparam int TIME_W  = 64;
   localparam int NOW_W   = 63;
   localparam int WIN_W   = 32;
   localparam int BIAS_W  = TIME_W + 1;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd30000;

   // Verdict codes
   localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [1:0] VERDICT_WINDOW = 2'd1;
   localparam logic [1:0] VERDICT_REPLAY = 2'd2;

   // One table slot: nonce halves and absolute expiry time
   typedef struct packed {
      logic [NONCE_W-1:0] nonce_upper;
      logic [NONCE_W-1:0] nonce_lower;
      logic [TIME_W-1:0]  expiry;
   } slot_entry_type;

endpackage

/* rtl/core/nonce_replay_cache.sv */
// Nonce replay cache: window check, table scan and insert of one request at a time.
//
// Each request is checked against the time window (message time within window_ms of the
// supplied present time); if it passes, the stored table is read one slot per cycle from a
// single synchronous memory and compared for a live entry with the same 128-bit nonce. If no
// replay is found the nonce is written at a wrapping insert cursor with expiry now plus
// window_ms. Before an accepted request presents its verdict, the scan reads every slot
// written since reset (at most ENTRIES = 16384) through the one memory read port, then
// compares the last slot and closes. A request rejected by the window check skips the scan,
// and a replay at slot k (counted from 0) ends the scan when that slot is compared.
// req_tready returns at the edge that registers the verdict, so the next request can be
// taken in the cycle after that edge at the earliest. Validity follows from the insert
// cursor and a table-full flag, so no clearing pass is needed after reset. One request is
// in work at a time; a new request is taken while the previous verdict still waits on the
// response channel.
module nonce_replay_cache
   import nrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request: nonce_upper[63:0], nonce_lower[127:64], msg_time[191:128],
   // current_time[254:192], zero pad[255]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,
   // response: verdict[1:0], zero pad[7:2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   // window_ms register
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_BOUND  = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   // Control registers
   logic [2:0]       state_ff, state_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic             full_ff, full_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rsp_vld_ff, rsp_vld_in;

   // Payload registers
   logic [NONCE_W-1:0] up_ff, up_in;
   logic [NONCE_W-1:0] lw_ff, lw_in;
   logic [TIME_W-1:0]  msg_ff, msg_in;
   logic [NOW_W-1:0]   now_ff, now_in;
   logic [BIAS_W-1:0]  lo_ff, lo_in;
   logic [BIAS_W-1:0]  hi_ff, hi_in;
   logic [1:0]         verdict_ff, verdict_in;
   logic [1:0]         rsp_verdict_ff, rsp_verdict_in;

   // Memory
   slot_entry_type   mem [ENTRIES];
   slot_entry_type   rd_data_ff;
   slot_entry_type   wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;

   logic [BIAS_W-1:0] biased_now;
   logic [BIAS_W-1:0] biased_msg;
   logic [CNT_W-1:0]  scan_len;
   logic              hit;
   logic              req_fire;
   logic              rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_verdict_ff};
   assign rsp_free   = !rsp_vld_ff || rsp_tready;

   // Bias both times so signed order becomes unsigned order, one extra bit of headroom
   assign biased_now = {2'b01, now_ff};
   assign biased_msg = {1'b0, ~msg_ff[TIME_W-1], msg_ff[TIME_W-2:0]};

   // Written slots: all once the cursor has wrapped, else those below the cursor
   assign scan_len = full_ff ? CNT_W'(ENTRIES) : {1'b0, cursor_ff};

   // Live entry with the same nonce
   assign hit = rd_vld_ff
             && rd_data_ff.nonce_upper == up_ff
             && rd_data_ff.nonce_lower == lw_ff
             && rd_data_ff.expiry > {1'b0, now_ff};

   assign rd_en   = (state_ff == S_SCAN) && (issue_cnt_ff < scan_len);
   assign rd_addr = issue_cnt_ff[IDX_W-1:0];
   assign wr_en   = (state_ff == S_WRITE);

   assign wr_data = '{nonce_upper: up_ff,
                      nonce_lower: lw_ff,
                      expiry:      {1'b0, now_ff} + {{(TIME_W-WIN_W){1'b0}}, window_ff}};

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      window_in      = csr_wr_en ? csr_wr_data : window_ff;
      cursor_in      = cursor_ff;
      full_in        = full_ff;
      issue_cnt_in   = issue_cnt_ff;
      rd_vld_in      = rd_en;
      rsp_vld_in     = rsp_vld_ff && !rsp_tready;
      up_in          = up_ff;
      lw_in          = lw_ff;
      msg_in         = msg_ff;
      now_in         = now_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      verdict_in     = verdict_ff;
      rsp_verdict_in = rsp_verdict_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               up_in    = req_tdata[63:0];
               lw_in    = req_tdata[127:64];
               msg_in   = req_tdata[191:128];
               now_in   = req_tdata[254:192];
               state_in = S_BOUND;
            end
         end
         S_BOUND: begin
            // Register the window bounds
            lo_in    = biased_now - {{(BIAS_W-WIN_W){1'b0}}, window_ff};
            hi_in    = biased_now + {{(BIAS_W-WIN_W){1'b0}}, window_ff};
            state_in = S_CHECK;
         end
         S_CHECK: begin
            issue_cnt_in = '0;
            if (biased_msg < lo_ff || biased_msg > hi_ff) begin
               verdict_in = VERDICT_WINDOW;
               state_in   = S_RESULT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Advance one slot a cycle; compare the slot read the cycle before
            if (rd_en) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (hit) begin
               verdict_in = VERDICT_REPLAY;
               rd_vld_in  = 1'b0;
               state_in   = S_RESULT;
            end else if (!rd_en && !rd_vld_ff) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // Store at the cursor and advance it with wrap
            if (cursor_ff == IDX_W'(ENTRIES - 1)) begin
               cursor_in = '0;
               full_in   = 1'b1;
            end else begin
               cursor_in = cursor_ff + 1'b1;
            end
            verdict_in = VERDICT_ACCEPT;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            // Hold until the response register is free
            if (rsp_free) begin
               rsp_vld_in     = 1'b1;
               rsp_verdict_in = verdict_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         cursor_ff    <= '0;
         full_ff      <= 1'b0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         cursor_ff    <= cursor_in;
         full_ff      <= full_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      up_ff          <= up_in;
      lw_ff          <= lw_in;
      msg_ff         <= msg_in;
      now_ff         <= now_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   // Slot table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cursor_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Checks
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_cnt_ff < scan_len))
      else $error("slot read beyond written range");

   a_write_moves_cursor: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (cursor_ff != $past(cursor_ff)))
      else $error("table write did not advance the cursor");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("table full flag dropped");

   a_no_read_during_write: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("read and write of the table overlap");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == S_RESULT))
      else $error("response raised outside the result step");

endmodule
